/* sv/arpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared widths, operation codes and defaults for the address cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int SLOT_W      = 3;
    localparam int OP_W        = 2;
    localparam int ENTRIES_DEF = 8;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

endpackage

/* sv/arpc_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_table
// Key and hardware-address memories with registered reads, plus
// per-entry occupancy flags that a clear drops all together.
// ----------------------------------------------------------------------------
module arpc_table
    import arpc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] key_rd_idx,
    input  logic [IDX_W-1:0] mac_rd_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [IP_W-1:0]  wr_key,
    input  logic [MAC_W-1:0] wr_mac,
    input  logic             clr,
    output logic [IP_W-1:0]  key_q,
    output logic             vld_q,
    output logic [MAC_W-1:0] mac_q
);

    logic [IP_W-1:0]  key_mem [ENTRIES];
    logic [MAC_W-1:0] mac_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx] <= wr_key;
        end
        key_q <= key_mem[key_rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mac_mem[wr_idx] <= wr_mac;
        end
        mac_q <= mac_mem[mac_rd_idx];
    end

    // an entry without its flag reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q     <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            vld_q <= valid_reg[key_rd_idx];
        end
    end

endmodule

/* sv/arp_address_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_address_cache
// Maps nonzero IPv4 addresses to 48-bit hardware addresses in a small table.
// ----------------------------------------------------------------------------
// Input beats carry operation, ip_address and mac_in; each gives exactly one
// output beat with hit, mac_out and slot. Operation lookup returns the first
// matching entry, update overwrites the match or fills the lowest empty entry
// (entry 0 when full), clear empties the table. Address zero never matches.
// One item at a time: a lookup or update scans the key memory one entry per
// cycle through its registered read port, stopping at the first match.
// Clear, address zero and unused codes skip the scan.
// The next beat is taken the cycle after the result is registered. The
// result register holds its beat until taken, and a new result waits
// behind it, so a receiver that stalls also holds off the input.
// Reset empties every entry at once; stored hardware addresses are not
// cleared, and no sweep is needed after reset.
// ----------------------------------------------------------------------------
module arp_address_cache
    import arpc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [IP_W-1:0]   ip_address,
    input  logic [MAC_W-1:0]  mac_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [MAC_W-1:0]  mac_out,
    output logic [SLOT_W-1:0] slot
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MAC_RD,
        ST_WRITE,
        ST_RESP
    } state_t;

    state_t             state_reg;
    logic [OP_W-1:0]    op_reg;
    logic [IP_W-1:0]    ip_reg;
    logic [MAC_W-1:0]   mac_in_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_on_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_on_reg;
    logic               empty_seen_reg;
    logic [IDX_W-1:0]   empty_idx_reg;
    logic [IDX_W-1:0]   wr_idx_reg;
    logic               res_hit_reg;
    logic               res_mac_sel_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic               out_valid_reg;
    logic               hit_reg;
    logic [MAC_W-1:0]   mac_out_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic [IP_W-1:0]    key_q;
    logic               vld_q;
    logic [MAC_W-1:0]   mac_q;
    logic               cmp_match;
    logic               cmp_last;
    logic               rd_last;
    logic [IDX_W-1:0]   upd_idx;
    logic               in_beat;
    logic               clr;
    logic               tbl_we;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign clr       = in_beat && (operation == OP_CLEAR);
    assign tbl_we    = (state_reg == ST_WRITE);

    assign cmp_match = vld_q && (key_q == ip_reg);
    assign cmp_last  = (cmp_idx_reg == LAST_IDX);
    assign rd_last   = (rd_idx_reg == LAST_IDX);

    // lowest empty entry, falling back to entry 0 on a full table
    always_comb
    begin
        if (empty_seen_reg)
        begin
            upd_idx = empty_idx_reg;
        end
        else if (!vld_q)
        begin
            upd_idx = cmp_idx_reg;
        end
        else
        begin
            upd_idx = '0;
        end
    end

    arpc_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_rd_idx (rd_idx_reg),
        .mac_rd_idx (wr_idx_reg),
        .wr_en      (tbl_we),
        .wr_idx     (wr_idx_reg),
        .wr_key     (ip_reg),
        .wr_mac     (mac_in_reg),
        .clr        (clr),
        .key_q      (key_q),
        .vld_q      (vld_q),
        .mac_q      (mac_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_LOOKUP;
            ip_reg          <= '0;
            mac_in_reg      <= '0;
            rd_idx_reg      <= '0;
            rd_on_reg       <= 1'b0;
            cmp_idx_reg     <= '0;
            cmp_on_reg      <= 1'b0;
            empty_seen_reg  <= 1'b0;
            empty_idx_reg   <= '0;
            wr_idx_reg      <= '0;
            res_hit_reg     <= 1'b0;
            res_mac_sel_reg <= 1'b0;
            res_slot_reg    <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            mac_out_reg     <= '0;
            slot_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg          <= operation;
                        ip_reg          <= ip_address;
                        mac_in_reg      <= mac_in;
                        rd_idx_reg      <= '0;
                        rd_on_reg       <= 1'b1;
                        cmp_on_reg      <= 1'b0;
                        empty_seen_reg  <= 1'b0;
                        res_hit_reg     <= 1'b0;
                        res_mac_sel_reg <= 1'b0;
                        res_slot_reg    <= '0;
                        if ((operation == OP_LOOKUP || operation == OP_UPDATE)
                            && ip_address != '0)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_RESP;
                        end
                    end
                end

                ST_SCAN:
                begin
                    // read issue runs one entry ahead of the compare
                    if (rd_on_reg)
                    begin
                        if (rd_last)
                        begin
                            rd_on_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                        end
                    end
                    cmp_on_reg  <= rd_on_reg;
                    cmp_idx_reg <= rd_idx_reg;

                    if (cmp_on_reg)
                    begin
                        if (!empty_seen_reg && !vld_q)
                        begin
                            empty_seen_reg <= 1'b1;
                            empty_idx_reg  <= cmp_idx_reg;
                        end
                        if (cmp_match)
                        begin
                            wr_idx_reg   <= cmp_idx_reg;
                            res_hit_reg  <= 1'b1;
                            res_slot_reg <= SLOT_W'(cmp_idx_reg);
                            if (op_reg == OP_LOOKUP)
                            begin
                                res_mac_sel_reg <= 1'b1;
                                state_reg       <= ST_MAC_RD;
                            end
                            else
                            begin
                                state_reg <= ST_WRITE;
                            end
                        end
                        else if (cmp_last)
                        begin
                            if (op_reg == OP_LOOKUP)
                            begin
                                state_reg <= ST_RESP;
                            end
                            else
                            begin
                                wr_idx_reg   <= upd_idx;
                                res_slot_reg <= SLOT_W'(upd_idx);
                                state_reg    <= ST_WRITE;
                            end
                        end
                    end
                end

                ST_MAC_RD:
                begin
                    state_reg <= ST_RESP;
                end

                ST_WRITE:
                begin
                    state_reg <= ST_RESP;
                end

                ST_RESP:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        hit_reg       <= res_hit_reg;
                        mac_out_reg   <= res_mac_sel_reg ? mac_q : '0;
                        slot_reg      <= res_slot_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign mac_out   = mac_out_reg;
    assign slot      = slot_reg;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARP address cache.
// ----------------------------------------------------------------------------
// Sends lookups, updates, clears and the unused operation code through the
// request channel. A scoreboard keeps its own copy of the address table,
// works out the reply each accepted request should produce and compares the
// reply beats in order. A directed sequence covers the table corners (address
// zero, table full, clear). Random traffic then draws most addresses from a
// small pool, so that hits, overwrites and slot 0 replacement are frequent.
// Idling on both channels changes between phases.
// ----------------------------------------------------------------------------
module testbench;
    import arpc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  mac;
        logic [SLOT_W-1:0] slot;
    } reply_t;

    class cache_scoreboard;
        logic [IP_W-1:0]  ip_keys [ENTRIES_DEF];
        logic [MAC_W-1:0] hw_addrs [ENTRIES_DEF];
        reply_t           replies_due [$];
        int               mismatches;
        int               checked;
        int               requests;
        int               lookup_hits;
        int               evictions;
        int               clears;

        function new();
            foreach (ip_keys[i])
            begin
                ip_keys[i]  = '0;
                hw_addrs[i] = '0;
            end
            mismatches  = 0;
            checked     = 0;
            requests    = 0;
            lookup_hits = 0;
            evictions   = 0;
            clears      = 0;
        endfunction

        function int find_key(logic [IP_W-1:0] ip);
            foreach (ip_keys[i])
                if (ip_keys[i] == ip)
                    return i;
            return ENTRIES_DEF;
        endfunction

        function int find_free();
            foreach (ip_keys[i])
                if (ip_keys[i] == '0)
                    return i;
            return ENTRIES_DEF;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
                                   logic [MAC_W-1:0] mac);
            reply_t r;
            int     idx;
            r = '0;
            requests++;
            if (op == OP_LOOKUP && ip != '0)
            begin
                idx = find_key(ip);
                if (idx < ENTRIES_DEF)
                begin
                    r.hit  = 1'b1;
                    r.mac  = hw_addrs[idx];
                    r.slot = SLOT_W'(idx);
                    lookup_hits++;
                end
            end
            else if (op == OP_UPDATE && ip != '0)
            begin
                idx = find_key(ip);
                if (idx < ENTRIES_DEF)
                    r.hit = 1'b1;
                else
                begin
                    idx = find_free();
                    // table full: entry 0 gives way
                    if (idx >= ENTRIES_DEF)
                    begin
                        idx = 0;
                        evictions++;
                    end
                end
                ip_keys[idx]  = ip;
                hw_addrs[idx] = mac;
                r.slot = SLOT_W'(idx);
            end
            else if (op == OP_CLEAR)
            begin
                // hardware addresses stay, only the keys go
                foreach (ip_keys[i])
                    ip_keys[i] = '0;
                clears++;
            end
            replies_due.push_back(r);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] reply %0d: %s", $realtime, checked, what);
        endfunction

        function void check_reply(logic h, logic [MAC_W-1:0] m, logic [SLOT_W-1:0] s);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                flag($sformatf("unexpected beat hit=%0b mac_out=%h slot=%0d", h, m, s));
                return;
            end
            want = replies_due.pop_front();
            checked++;
            if (h !== want.hit)
                flag($sformatf("hit expected %0b, got %0b", want.hit, h));
            if (m !== want.mac)
                flag($sformatf("mac_out expected %h, got %h", want.mac, m));
            if (s !== want.slot)
                flag($sformatf("slot expected %0d, got %0d", want.slot, s));
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   operation = '0;
    logic [IP_W-1:0]   ip_address = '0;
    logic [MAC_W-1:0]  mac_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              hit;
    logic [MAC_W-1:0]  mac_out;
    logic [SLOT_W-1:0] slot;

    cache_scoreboard   sb;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                idle_cycles = 0;
    logic [IP_W-1:0]   addr_pool [16];
    int                pool_size = 1;

    arp_address_cache u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .ip_address (ip_address),
        .mac_in     (mac_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .mac_out    (mac_out),
        .slot       (slot)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_reply(hit, mac_out, slot);
            if (in_valid && !in_stall)
                sb.note_request(operation, ip_address, mac_in);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("arp_address_cache: mismatch");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip,
                             input logic [MAC_W-1:0] mac);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        ip_address <= ip;
        mac_in     <= mac;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() > 0)
            @(negedge clk);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    task automatic refresh_pool();
        pool_size = $urandom_range(4, 14);
        foreach (addr_pool[i])
            do
                addr_pool[i] = $urandom();
            while (addr_pool[i] == '0);
    endtask

    task automatic run_directed();
        send_item(OP_LOOKUP, '0, '1);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_UPDATE, '0, '1);
        send_item(OP_UPDATE, '1, '1);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_UPDATE, 32'd1, '0);
        send_item(OP_LOOKUP, 32'd1, rand_mac());
        send_item(OP_UPDATE, 32'd1, 48'haaaa_aaaa_aaaa);
        // fill the rest of the table, then one more to force slot 0 out
        for (int i = 2; i < ENTRIES_DEF; i++)
            send_item(OP_UPDATE, IP_W'(i), rand_mac());
        send_item(OP_UPDATE, 32'h8000_0000, 48'h5555_5555_5555);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_LOOKUP, 32'h8000_0000, '0);
        send_item(OP_LOOKUP, IP_W'(ENTRIES_DEF - 1), '0);
        send_item(OP_UNUSED, 32'd5, '1);
        send_item(OP_LOOKUP, 32'd5, '0);
        send_item(OP_CLEAR, 32'd5, '1);
        send_item(OP_LOOKUP, 32'd5, '0);
        send_item(OP_UPDATE, 32'h5555_5555, rand_mac());
        send_item(OP_LOOKUP, 32'h5555_5555, '0);
    endtask

    task automatic run_random(input int count);
        int               pick;
        int               sel;
        logic [OP_W-1:0]  op;
        logic [IP_W-1:0]  ip;
        for (int k = 0; k < count; k++)
        begin
            if (k % 100 == 0)
                refresh_pool();
            if ($urandom_range(99) < 2)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 45)
                op = OP_LOOKUP;
            else if (pick < 86)
                op = OP_UPDATE;
            else if (pick < 90)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            sel = $urandom_range(99);
            if (sel < 7)
                ip = '0;
            else if (sel < 17)
                ip = $urandom();
            else
                ip = addr_pool[$urandom_range(pool_size - 1)];
            send_item(op, ip, rand_mac());
        end
    endtask

    initial
    begin
        sb = new();
        refresh_pool();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 15;
        stall_pct     = 15;
        run_directed();
        wait_drained();

        send_idle_pct = 29;
        stall_pct     = 87;
        run_random(340);
        wait_drained();

        send_idle_pct = 87;
        stall_pct     = 29;
        run_random(330);
        wait_drained();

        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(330);
        wait_drained();

        // a late stray beat would still be caught here
        repeat (20) @(negedge clk);

        $display("%0d requests sent: %0d lookup hits, %0d full-table replacements, %0d clears",
                 sb.requests, sb.lookup_hits, sb.evictions, sb.clears);
        $display("%0d reply beats checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("arp_address_cache: match");
        else
            $display("arp_address_cache: mismatch");
        $finish;
    end

endmodule
